// ----- hw/rtl/vrp_pkg.sv -----
package vrp_pkg;

   localparam int ANGLE_BITS   = 10;
   localparam int QUARTER_BITS = ANGLE_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;

   localparam int COORD_W   = 16;
   localparam int TRIG_W    = 16;
   localparam int TRIG_FRAC = 14;
   localparam int FOV_W     = 10;
   localparam int CENTER_W  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;

   localparam int PROD_W = 2 * COORD_W;
   localparam int DEN_W  = 32;
   localparam int MUL_W  = DEN_W + FOV_W + 1;
   localparam int NUM_W  = MUL_W + 1;
   localparam int Q_BITS = COORD_W + 1;
   localparam int REM_W  = DEN_W + Q_BITS - 1;
   localparam int CMP_W  = DEN_W + Q_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOV    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd4;

   localparam logic [ANGLE_BITS-1:0] ANGLE_RESET  = '0;
   localparam logic [FOV_W-1:0]      FOV_RESET    = 10'd200;
   localparam logic [CSR_W-1:0]      DIST_RESET   = 16'd1280;
   localparam logic [CENTER_W-1:0]   CENTER_X_RESET = 10'd160;
   localparam logic [CENTER_W-1:0]   CENTER_Y_RESET = 10'd100;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [Q_BITS-1:0] quo;
      logic              neg;
      logic              ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type     lane_x;
      div_lane_type     lane_y;
      logic [REM_W-1:0] dsh;
      logic             fault;
   } div_data_type;

   typedef logic [TRIG_W-1:0] sine_rom_type [QUARTER+1];

   // shift and subtract quotient, only used while building the table
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // taylor series sine in q30, rounded to q1.14
   function automatic logic [TRIG_W-1:0] rom_entry(int unsigned idx);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum_pos;
      longint unsigned sum_neg;
      longint unsigned s;
      x = (longint'(idx) * HALF_PI_Q30 + longint'(QUARTER >> 1)) >> QUARTER_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum_pos = x;
      sum_neg = 0;
      for (int k = 1; k <= 8; k++) begin
         term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
         if (k[0]) begin
            sum_neg = sum_neg + term;
         end else begin
            sum_pos = sum_pos + term;
         end
      end
      s = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
      s = (s + 64'd32768) >> 16;
      if (s > 64'd16384) begin
         s = 64'd16384;
      end
      return TRIG_W'(s);
   endfunction

   function automatic sine_rom_type build_rom();
      sine_rom_type rom;
      for (int i = 0; i <= QUARTER; i++) begin
         rom[i] = rom_entry(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_rom();

   function automatic logic signed [TRIG_W-1:0] sine_of(logic [ANGLE_BITS-1:0] phase);
      logic [1:0]              quad;
      logic [QUARTER_BITS-1:0] r;
      logic [QUARTER_BITS:0]   idx;
      logic [TRIG_W-1:0]       mag;
      quad = phase[ANGLE_BITS-1 -: 2];
      r = phase[QUARTER_BITS-1:0];
      idx = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      mag = SINE_ROM[idx];
      return quad[1] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ----- hw/rtl/vrp_chan_if.sv -----
interface vrp_vertex_if;
   logic                                valid;
   logic                                ready;
   logic signed [vrp_pkg::COORD_W-1:0]  vertex_x;
   logic signed [vrp_pkg::COORD_W-1:0]  vertex_y;
   logic signed [vrp_pkg::COORD_W-1:0]  vertex_z;

   modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                   input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                 output ready);
endinterface

interface vrp_screen_if;
   logic                                valid;
   logic                                ready;
   logic signed [vrp_pkg::COORD_W-1:0]  screen_x;
   logic signed [vrp_pkg::COORD_W-1:0]  screen_y;
   logic                                div_fault;

   modport source (output valid, output screen_x, output screen_y, output div_fault,
                   input ready);
   modport sink (input valid, input screen_x, input screen_y, input div_fault,
                 output ready);
endinterface

// ----- hw/rtl/vrp_div_cell.sv -----
module vrp_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vrp_pkg::div_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vrp_pkg::div_data_type out_data
);
   import vrp_pkg::*;

   logic         valid_ff;
   div_data_type data_ff;
   div_data_type data_in;

   // one restoring step: compare, subtract, shift in a quotient bit
   function automatic div_lane_type lane_step(div_lane_type l, logic [REM_W-1:0] dsh);
      div_lane_type n;
      logic         ge;
      n = l;
      ge = (l.rem >= dsh);
      n.rem = ge ? (l.rem - dsh) : l.rem;
      n.quo = {l.quo[Q_BITS-2:0], ge};
      return n;
   endfunction

   always_comb begin
      data_in = in_data;
      data_in.lane_x = lane_step(in_data.lane_x, in_data.dsh);
      data_in.lane_y = lane_step(in_data.lane_y, in_data.dsh);
      data_in.dsh = in_data.dsh >> 1;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hw/rtl/vertex_rotate_y_perspective_project_unit.sv -----
// channel   dir  handshake         payload
// req_chan  in   valid/ready       vertex_x, vertex_y, vertex_z (signed q8.8)
// rsp_chan  out  valid/ready       screen_x, screen_y, div_fault
// csr_*     in   write enable only csr_index, csr_data
//
// one vertex per clock sustained while rsp_chan is ready; the path is six arithmetic stages,
// a row of 17 divider cells (one quotient bit each) and the output register
// reset is synchronous, clears valid bits and loads the register defaults
// each stage holds its item only while the next one is full and stalled,
// so bubbles close up and input keeps flowing while a result waits
module vertex_rotate_y_perspective_project_unit (
   input  logic                                clock,
   input  logic                                reset,
   vrp_vertex_if.sink                          req_chan,
   vrp_screen_if.source                        rsp_chan,
   input  logic                                csr_write_en,
   input  logic [vrp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vrp_pkg::CSR_W-1:0]           csr_data
);
   import vrp_pkg::*;

   // configuration registers
   logic [ANGLE_BITS-1:0] angle_ff;
   logic [FOV_W-1:0]      fov_ff;
   logic [CSR_W-1:0]      dist_ff;
   logic [CENTER_W-1:0]   cx_ff;
   logic [CENTER_W-1:0]   cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= ANGLE_RESET;
         fov_ff   <= FOV_RESET;
         dist_ff  <= DIST_RESET;
         cx_ff    <= CENTER_X_RESET;
         cy_ff    <= CENTER_Y_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ANGLE:    angle_ff <= csr_data[ANGLE_BITS-1:0];
            CSR_FOV:      fov_ff   <= csr_data[FOV_W-1:0];
            CSR_DIST:     dist_ff  <= csr_data;
            CSR_CENTER_X: cx_ff    <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Y: cy_ff    <= csr_data[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // stage ready chain: a stage takes new data when empty or draining
   logic r1, r2, r3, r4, r5, r6;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic out_ready;
   logic chain_valid [Q_BITS+1];
   logic chain_ready [Q_BITS+1];
   div_data_type chain_data [Q_BITS+1];

   assign r6 = !v6_ff || chain_ready[0];
   assign r5 = !v5_ff || r6;
   assign r4 = !v4_ff || r5;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign req_chan.ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_chan.valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
      end
   end

   // stage 1: capture vertex, sine and cosine lookup
   logic signed [COORD_W-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [TRIG_W-1:0]  sn1_ff, cs1_ff;
   logic [ANGLE_BITS-1:0]     cos_phase;

   assign cos_phase = angle_ff + ANGLE_BITS'(QUARTER);

   always_ff @(posedge clock) begin
      if (r1 && req_chan.valid) begin
         x1_ff  <= req_chan.vertex_x;
         y1_ff  <= req_chan.vertex_y;
         z1_ff  <= req_chan.vertex_z;
         sn1_ff <= sine_of(angle_ff);
         cs1_ff <= sine_of(cos_phase);
      end
   end

   // stage 2: rotation products
   logic signed [PROD_W-1:0]  xc2_ff, zs2_ff, xs2_ff, zc2_ff;
   logic signed [COORD_W-1:0] y2_ff;

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         xc2_ff <= x1_ff * cs1_ff;
         zs2_ff <= z1_ff * sn1_ff;
         xs2_ff <= x1_ff * sn1_ff;
         zc2_ff <= z1_ff * cs1_ff;
         y2_ff  <= y1_ff;
      end
   end

   // stage 3: rotated x, scaled y, denominator zr + distance
   logic signed [DEN_W-1:0] xr3_ff, yr3_ff, den3_ff;
   logic signed [DEN_W-1:0] dist_scaled;

   assign dist_scaled = DEN_W'($signed({dist_ff, {TRIG_FRAC{1'b0}}}));

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         xr3_ff  <= DEN_W'(xc2_ff) - DEN_W'(zs2_ff);
         den3_ff <= DEN_W'(xs2_ff) + DEN_W'(zc2_ff) + dist_scaled;
         yr3_ff  <= DEN_W'($signed({y2_ff, {TRIG_FRAC{1'b0}}}));
      end
   end

   // stage 4: scale by field of view and centre times denominator
   logic signed [MUL_W-1:0] fx4_ff, fy4_ff, cxd4_ff, cyd4_ff;
   logic signed [DEN_W-1:0] den4_ff;

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         fx4_ff  <= $signed({1'b0, fov_ff}) * xr3_ff;
         fy4_ff  <= $signed({1'b0, fov_ff}) * yr3_ff;
         cxd4_ff <= $signed({1'b0, cx_ff}) * den3_ff;
         cyd4_ff <= $signed({1'b0, cy_ff}) * den3_ff;
         den4_ff <= den3_ff;
      end
   end

   // stage 5: numerators and fault detect
   logic signed [NUM_W-1:0] nx5_ff, ny5_ff;
   logic signed [DEN_W-1:0] den5_ff;
   logic                    fault5_ff;

   always_ff @(posedge clock) begin
      if (r5 && v4_ff) begin
         nx5_ff    <= NUM_W'(fx4_ff) + NUM_W'(cxd4_ff);
         ny5_ff    <= NUM_W'(fy4_ff) + NUM_W'(cyd4_ff);
         den5_ff   <= den4_ff;
         fault5_ff <= (den4_ff == '0);
      end
   end

   // stage 6: magnitudes, quotient signs, overflow screen for the divider
   logic [DEN_W-1:0] den_mag;
   logic [NUM_W-1:0] nx_mag, ny_mag;
   logic [CMP_W-1:0] den_lim;
   div_data_type     div_in;
   div_data_type     div6_ff;

   always_comb begin
      den_mag = den5_ff[DEN_W-1] ? DEN_W'(-den5_ff) : DEN_W'(den5_ff);
      nx_mag  = nx5_ff[NUM_W-1] ? NUM_W'(-nx5_ff) : NUM_W'(nx5_ff);
      ny_mag  = ny5_ff[NUM_W-1] ? NUM_W'(-ny5_ff) : NUM_W'(ny5_ff);
      den_lim = {den_mag, {Q_BITS{1'b0}}};
      div_in.lane_x.rem = REM_W'(nx_mag);
      div_in.lane_x.quo = '0;
      div_in.lane_x.neg = nx5_ff[NUM_W-1] ^ den5_ff[DEN_W-1];
      div_in.lane_x.ovf = (CMP_W'(nx_mag) >= den_lim);
      div_in.lane_y.rem = REM_W'(ny_mag);
      div_in.lane_y.quo = '0;
      div_in.lane_y.neg = ny5_ff[NUM_W-1] ^ den5_ff[DEN_W-1];
      div_in.lane_y.ovf = (CMP_W'(ny_mag) >= den_lim);
      div_in.dsh = REM_W'({den_mag, {(Q_BITS-1){1'b0}}});
      div_in.fault = fault5_ff;
   end

   always_ff @(posedge clock) begin
      if (r6 && v5_ff) begin
         div6_ff <= div_in;
      end
   end

   // divider row, most significant quotient bit first
   assign chain_valid[0] = v6_ff;
   assign chain_data[0]  = div6_ff;
   assign chain_ready[Q_BITS] = out_ready;

   for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
      vrp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // sign, saturation and fault override
   function automatic logic [COORD_W-1:0] finish(div_lane_type l, logic fault);
      logic [COORD_W-1:0] v;
      logic [Q_BITS-1:0]  neg_q;
      neg_q = -l.quo;
      priority if (fault) begin
         v = '0;
      end else if (l.ovf) begin
         v = l.neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else if (l.neg) begin
         v = (l.quo > {2'b01, {(Q_BITS-2){1'b0}}}) ? {1'b1, {(COORD_W-1){1'b0}}}
                                                 : neg_q[COORD_W-1:0];
      end else begin
         v = (l.quo[Q_BITS-1] || l.quo[Q_BITS-2]) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                  : l.quo[COORD_W-1:0];
      end
      return v;
   endfunction

   logic               rsp_valid_ff;
   logic [COORD_W-1:0] sx_ff, sy_ff;
   logic               fault_ff;

   assign out_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain_valid[Q_BITS];
      end
      if (out_ready && chain_valid[Q_BITS]) begin
         sx_ff    <= finish(chain_data[Q_BITS].lane_x, chain_data[Q_BITS].fault);
         sy_ff    <= finish(chain_data[Q_BITS].lane_y, chain_data[Q_BITS].fault);
         fault_ff <= chain_data[Q_BITS].fault;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.screen_x  = $signed(sx_ff);
   assign rsp_chan.screen_y  = $signed(sy_ff);
   assign rsp_chan.div_fault = fault_ff;

endmodule

// ----- tb/vrp_checker.sv -----
module vrp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [15:0]               req_x,
   input  logic signed [15:0]               req_y,
   input  logic signed [15:0]               req_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [15:0]               rsp_x,
   input  logic signed [15:0]               rsp_y,
   input  logic                             rsp_fault,
   input  logic                             csr_write_en,
   input  logic [vrp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vrp_pkg::CSR_W-1:0]        csr_data,
   output int                               fail_count,
   output int                               pending
);
   import vrp_pkg::*;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic               fault;
   } screen_point_type;

   logic [9:0]  angle;
   logic [9:0]  fov;
   logic [15:0] dist_reg;
   logic [9:0]  cx;
   logic [9:0]  cy;
   screen_point_type projected_q[$];
   logic [15:0] sine_tab [QUARTER+1];

   // own quarter-wave table, same taylor construction
   function automatic longint sine_mag(int idx);
      longint unsigned t, t2, term, sp, sn, s;
      t = (longint'(idx) * 64'd1686629713 + 64'd128) >> 8;
      t2 = (t * t) >> 30;
      term = t;
      sp = t;
      sn = 0;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sn += term;
         else sp += term;
      end
      s = (sp > sn) ? sp - sn : 0;
      s = (s + 64'd32768) >> 16;
      if (s > 16384) s = 16384;
      return longint'(s);
   endfunction

   function automatic longint wave(int p);
      int q, r;
      p = p & 1023;
      q = p >> 8;
      r = p & 255;
      case (q)
         0: return sine_tab[r];
         1: return sine_tab[256 - r];
         2: return -longint'(sine_tab[r]);
         default: return -longint'(sine_tab[256 - r]);
      endcase
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic screen_point_type project_vertex(longint x, longint y, longint z);
      screen_point_type p;
      longint sn, cs, xr, zr, den;
      sn = wave(angle);
      cs = wave(angle + 256);
      xr = x * cs - z * sn;
      zr = x * sn + z * cs;
      den = zr + longint'($signed(dist_reg)) * 16384;
      if (den == 0) begin
         p = '{sx: 16'sd0, sy: 16'sd0, fault: 1'b1};
      end else begin
         p.sx = clamp16((longint'(fov) * xr + longint'(cx) * den) / den);
         p.sy = clamp16((longint'(fov) * y * 16384 + longint'(cy) * den) / den);
         p.fault = 1'b0;
      end
      return p;
   endfunction

   initial begin
      for (int i = 0; i <= QUARTER; i++) sine_tab[i] = 16'(sine_mag(i));
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      screen_point_type e;
      if (reset) begin
         angle    <= ANGLE_RESET;
         fov      <= FOV_RESET;
         dist_reg <= DIST_RESET;
         cx       <= CENTER_X_RESET;
         cy       <= CENTER_Y_RESET;
         projected_q.delete();
         pending <= 0;
      end else begin
         if (req_valid && req_ready)
            projected_q.push_back(project_vertex(req_x, req_y, req_z));
         if (rsp_valid && rsp_ready) begin
            if (projected_q.size() == 0) begin
               $display("%0t unexpected transfer x=%0d y=%0d f=%0b",
                        $time, rsp_x, rsp_y, rsp_fault);
               fail_count <= fail_count + 1;
            end else begin
               e = projected_q.pop_front();
               if (e.sx !== rsp_x || e.sy !== rsp_y || e.fault !== rsp_fault) begin
                  $display("%0t mismatch expected x=%0d y=%0d f=%0b actual x=%0d y=%0d f=%0b",
                           $time, e.sx, e.sy, e.fault, rsp_x, rsp_y, rsp_fault);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= projected_q.size();
         if (csr_write_en) begin
            case (csr_index)
               CSR_ANGLE:    angle    <= csr_data[9:0];
               CSR_FOV:      fov      <= csr_data[9:0];
               CSR_DIST:     dist_reg <= csr_data;
               CSR_CENTER_X: cx       <= csr_data[9:0];
               CSR_CENTER_Y: cy       <= csr_data[9:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/testbench.sv -----
module testbench;
   import vrp_pkg::*;

   localparam int LATENCY = 24;
   localparam int LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;
   int fail_count;
   int pending;
   int cycles = 0;
   int send_idle_pct = 0;  // chance of a gap before each vertex
   int stall_pct = 0;      // chance the receiver holds ready low

   vrp_vertex_if req_chan ();
   vrp_screen_if rsp_chan ();

   vertex_rotate_y_perspective_project_unit u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   vrp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_x(req_chan.vertex_x), .req_y(req_chan.vertex_y), .req_z(req_chan.vertex_z),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_x(rsp_chan.screen_x), .rsp_y(rsp_chan.screen_y), .rsp_fault(rsp_chan.div_fault),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.vertex_x = '0;
      req_chan.vertex_y = '0;
      req_chan.vertex_z = '0;
      rsp_chan.ready = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL vertex_rotate_y_perspective_project_unit");
         $finish;
      end
   end

   // one vertex transfer; valid stays high across back-to-back items
   task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.vertex_x <= x;
      req_chan.vertex_y <= y;
      req_chan.vertex_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // enable stays high across a burst of writes, the caller drops it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic set_view(input int ang, input int fv, input int dst,
                           input int cxv, input int cyv);
      write_reg(CSR_ANGLE, CSR_W'(ang));
      write_reg(CSR_FOV, CSR_W'(fv));
      write_reg(CSR_DIST, CSR_W'(dst));
      write_reg(CSR_CENTER_X, CSR_W'(cxv));
      write_reg(CSR_CENTER_Y, CSR_W'(cyv));
      csr_write_en <= 1'b0;
   endtask

   // random vertex: mostly a modest model-sized range, sometimes full range
   task automatic send_random();
      if ($urandom_range(3) == 0)
         send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
      else
         send_vertex(16'($urandom_range(1024) - 512), 16'($urandom_range(1024) - 512),
                     16'($urandom_range(1024) - 512));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, field extremes
      send_vertex(16'h0000, 16'h0000, 16'h0000);
      send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
      send_vertex(16'h8000, 16'h8000, 16'h8000);
      send_vertex(16'h0100, 16'hff00, 16'h0100);
      // rotated z cancels the distance: zero denominator
      send_vertex(16'h0000, 16'h0100, -16'sd1280);
      // behind the viewer: negative denominator
      send_vertex(16'h0080, 16'h0080, -16'sd2560);
      drain();

      // quarter turn, zero fov, zero distance
      set_view(256, 0, 0, 0, 0);
      send_vertex(16'h0000, 16'h0100, 16'h0000);   // zero denominator
      send_vertex(16'h0100, 16'h0100, 16'h0000);
      send_vertex(16'h8000, 16'h7fff, 16'h7fff);
      drain();

      // every extreme register value; saturation
      set_view(1023, 1023, 16'h7fff, 1023, 1023);
      send_vertex(16'h7fff, 16'h7fff, 16'h8000);
      send_vertex(16'h0001, 16'h8000, 16'h0001);
      drain();
      set_view(512, 1023, 16'h8000, 0, 1023);
      send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
      send_vertex(16'h0000, 16'h0000, 16'h8000);
      send_vertex(16'h0001, 16'h0001, 16'h0001);  // large negative denominator from the distance
      drain();
      set_view(768, 1, 1, 512, 512);
      send_vertex(16'h0000, 16'h7fff, 16'h0000);
      send_vertex(16'h0001, 16'h0001, 16'h0000);
      drain();

      // random phases, each with a fresh view and an idling mode
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         if (ph % 3 == 0)
            set_view($urandom_range(1023), $urandom_range(1023), $urandom,
                     $urandom_range(1023), $urandom_range(1023));
         else
            set_view($urandom_range(1023), $urandom_range(400),
                     $urandom_range(4096) - 2048 + 1280,
                     $urandom_range(320), $urandom_range(200));
         for (int n = 0; n < 42; n++) send_random();
         drain();
      end

      if (fail_count == 0)
         $display("PASS vertex_rotate_y_perspective_project_unit");
      else
         $display("FAIL vertex_rotate_y_perspective_project_unit");
      $finish;
   end
endmodule
